FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ARE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ARE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/are_pkg.sv
// Package with widths, codes and defaults of the ARP resolution engine.
package are_pkg;

  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int HANDLE_W   = 16;
  localparam int MS_W       = 32;
  localparam int NOW_W      = 64;
  localparam int KIND_W     = 2;
  localparam int ACTION_W   = 3;
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int RES_CNT_W  = 7;
  localparam int MAX_RESULTS = 64;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int PENDING_ENTRIES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 8;

  localparam logic [MAC_W-1:0] BCAST_MAC           = '1;
  localparam logic [MS_W-1:0]  CACHE_LIFETIME_RST  = 32'd30000;
  localparam logic [MS_W-1:0]  REQUEST_TIMEOUT_RST = 32'd5000;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND = 2'd0,
    KIND_ARP  = 2'd1,
    KIND_IPV4 = 2'd2,
    KIND_TICK = 2'd3
  } kind_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TX      = 3'd0,
    ACT_REQUEST = 3'd1,
    ACT_REPLY   = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_DISCARD = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_MAC         = 2'd0,
    REG_OWN_IP          = 2'd1,
    REG_CACHE_LIFETIME  = 2'd2,
    REG_REQUEST_TIMEOUT = 2'd3
  } cfg_reg_e;

endpackage

FILE: rtl/are_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module are_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/arp_resolution_engine_top.sv
// Top level of the ARP resolution engine: scan control, tables and result register.
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tuser kind, tdata request fields
//  m_axis  | out | m_axis_tvalid/tready  | tuser action, tdata result, tlast
//  cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One item at a time. Cache and pending scans read their table one entry at a time
// through the one read port of each table; a queued handle is read from the queue
// RAM in ST_FRD and sent in ST_FEM. A send on a cache hit skips the pending scan.
// Reset clears valid bits and counts at once. A stalled result register holds the
// engine in any step that emits a result.
`include "assert_macros.svh"

module arp_resolution_engine_top #(
  parameter int CACHE_ENTRIES   = are_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = are_pkg::PENDING_ENTRIES_DEF,
  parameter int QUEUE_DEPTH     = are_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // frame_dst_mac, peer_ip, arp_target_ip, arp_sender_mac, arp_is_request,
  // payload_ok, buffer_handle, elapsed_ms, zero fill
  input  logic [are_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic [are_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // dst_mac, arp_ip, out_handle
  output logic [are_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // action
  output logic [are_pkg::ACTION_W-1:0]    m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [are_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [are_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import are_pkg::*;

  localparam int CW     = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW     = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW   = $clog2(QUEUE_DEPTH + 1);
  localparam int IW     = (CW > PW) ? CW : PW;
  localparam int SCW    = IW + 1;
  localparam int QAW    = PW + QW;
  localparam int CENT_W = IP_W + MAC_W + NOW_W;
  localparam int PENT_W = IP_W + NOW_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CSCAN, ST_CWR, ST_PSCAN, ST_TX, ST_DLV, ST_DISC, ST_REQ,
    ST_ENQ, ST_REPLY, ST_ARPF, ST_TNEXT, ST_FRD, ST_FEM
  } state_e;

  state_e state_q, state_d;

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;
  logic [MS_W-1:0]  life_q, tmo_q;

  kind_e               kind_q;
  logic [IP_W-1:0]     peer_q, target_q;
  logic [MAC_W-1:0]    smac_q;
  logic                isreq_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [NOW_W-1:0]   now_q, now_d;
  logic [SCW-1:0]     sc_q, sc_d;
  logic               pv_q, pv_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic               hit_q, hit_d;
  logic [CW-1:0]      hidx_q, hidx_d;
  logic [MAC_W-1:0]   hmac_q, hmac_d;
  logic               minv_q, minv_d;
  logic [NOW_W-1:0]   minst_q, minst_d;
  logic [CW-1:0]      minidx_q, minidx_d;
  logic [CW-1:0]      wslot_q, wslot_d;
  logic               pm_q, pm_d;
  logic [PW-1:0]      pslot_q, pslot_d;
  logic [PW-1:0]      slot_q, slot_d;
  logic [CNTW-1:0]    j_q, j_d;
  logic [RES_CNT_W-1:0] n_q, n_d;
  logic [CACHE_ENTRIES-1:0]   cache_v_q, cache_v_d;
  logic [PENDING_ENTRIES-1:0] pend_v_q, pend_v_d;
  logic [PENDING_ENTRIES-1:0] mask_q, mask_d;
  logic [CNTW-1:0] qcnt_q [PENDING_ENTRIES];
  logic [CNTW-1:0] qcnt_d [PENDING_ENTRIES];

  logic                mv_q;
  logic [ACTION_W-1:0] o_action_q;
  logic [MAC_W-1:0]    o_mac_q;
  logic [IP_W-1:0]     o_ip_q;
  logic [HANDLE_W-1:0] o_handle_q;
  logic                o_last_q;

  logic               c_re, c_we, p_re, p_we, q_re, q_we;
  logic [CENT_W-1:0]  c_rdata, c_wdata;
  logic [PENT_W-1:0]  p_rdata;
  logic [HANDLE_W-1:0] q_rdata;
  logic [QAW-1:0]     q_waddr;
  logic [CW-1:0]      c_wsel;

  logic [IP_W-1:0]  c_ip, p_ip;
  logic [MAC_W-1:0] c_mac;
  logic [NOW_W-1:0] c_stamp, p_stamp;

  logic                   in_fire, out_free, emit_load;
  logic                   e_v, e_last;
  action_e                e_action;
  logic [MAC_W-1:0]       e_mac;
  logic [IP_W-1:0]        e_ip;
  logic [HANDLE_W-1:0]    e_handle;
  logic [MAC_W-1:0]       in_dst;
  logic                   in_ok, dst_hit;
  logic [CACHE_ENTRIES-1:0]   c_free_any;
  logic [CW-1:0]          c_free_idx;
  logic [PW-1:0]          p_free_idx;
  logic [PENDING_ENTRIES-1:0] nz, em;
  logic [PW-1:0]          em_idx;
  logic [CNTW-1:0]        cur_cnt;
  logic                   last_j;

  assign in_dst  = s_axis_tdata[47:0];
  assign in_ok   = s_axis_tdata[161];
  assign dst_hit = ((in_dst == own_mac_q) || (in_dst == BCAST_MAC)) && in_ok;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free  = !mv_q || m_axis_tready;
  assign emit_load = e_v && (n_q < RES_CNT_W'(MAX_RESULTS));

  assign c_stamp = c_rdata[NOW_W-1:0];
  assign c_mac   = c_rdata[NOW_W+MAC_W-1:NOW_W];
  assign c_ip    = c_rdata[CENT_W-1:NOW_W+MAC_W];
  assign p_stamp = p_rdata[NOW_W-1:0];
  assign p_ip    = p_rdata[PENT_W-1:NOW_W];
  assign c_wdata = {peer_q, smac_q, now_q};
  assign cur_cnt = qcnt_q[slot_q];

  always_comb begin
    c_free_idx = '0;
    c_free_any = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      c_free_any[i] = !cache_v_q[i];
      if (!cache_v_q[i]) begin
        c_free_idx = CW'(i);
      end
    end
    p_free_idx = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      if (!pend_v_q[i]) begin
        p_free_idx = PW'(i);
      end
    end
    em_idx = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      nz[i] = (qcnt_q[i] != '0);
      em[i] = mask_q[i] && nz[i];
      if (em[i]) begin
        em_idx = PW'(i);
      end
    end
  end

  assign c_wsel = hit_q ? hidx_q : ((|c_free_any) ? c_free_idx : minidx_q);
  assign q_waddr = (state_q == ST_REQ) ? {slot_q, {QW{1'b0}}} : {slot_q, cur_cnt[QW-1:0]};
  assign last_j  = ({1'b0, j_q} == ({1'b0, cur_cnt} - (CNTW+1)'(1)));

  always_comb begin
    state_d = state_q; now_d = now_q; sc_d = sc_q; pv_d = 1'b0; pidx_d = pidx_q;
    hit_d = hit_q; hidx_d = hidx_q; hmac_d = hmac_q; minv_d = minv_q;
    minst_d = minst_q; minidx_d = minidx_q; wslot_d = wslot_q; pm_d = pm_q;
    pslot_d = pslot_q; slot_d = slot_q; j_d = j_q; n_d = n_q;
    cache_v_d = cache_v_q; pend_v_d = pend_v_q; mask_d = mask_q; qcnt_d = qcnt_q;
    c_re = 1'b0; c_we = 1'b0; p_re = 1'b0; p_we = 1'b0; q_re = 1'b0; q_we = 1'b0;
    e_v = 1'b0; e_last = 1'b0; e_action = ACT_TX; e_mac = '0; e_ip = '0; e_handle = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          n_d = '0; sc_d = '0; hit_d = 1'b0; minv_d = 1'b0; pm_d = 1'b0; mask_d = '0;
          case (kind_e'(s_axis_tuser))
            KIND_SEND: state_d = ST_CSCAN;
            KIND_ARP:  state_d = dst_hit ? ST_CSCAN : ST_IDLE;
            KIND_IPV4: state_d = dst_hit ? ST_DLV : ST_IDLE;
            KIND_TICK: begin
              now_d   = now_q + NOW_W'(s_axis_tdata[209:178]);
              state_d = ST_CSCAN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CSCAN: begin
        if (sc_q < SCW'(CACHE_ENTRIES)) begin
          c_re = 1'b1; sc_d = sc_q + 1'b1; pv_d = 1'b1; pidx_d = sc_q[IW-1:0];
        end
        if (pv_q && cache_v_q[pidx_q[CW-1:0]]) begin
          if (kind_q == KIND_TICK) begin
            if ((now_q - c_stamp) > NOW_W'(life_q)) begin
              cache_v_d[pidx_q[CW-1:0]] = 1'b0;
            end
          end else begin
            if (!hit_q && c_ip == peer_q) begin
              hit_d = 1'b1; hidx_d = pidx_q[CW-1:0]; hmac_d = c_mac;
            end
            if (!minv_q || c_stamp < minst_q) begin
              minv_d = 1'b1; minst_d = c_stamp; minidx_d = pidx_q[CW-1:0];
            end
          end
        end
        if (sc_q == SCW'(CACHE_ENTRIES) && !pv_q) begin
          sc_d = '0;
          if (kind_q == KIND_SEND && hit_q) state_d = ST_TX;
          else if (kind_q == KIND_ARP) state_d = ST_CWR;
          else state_d = ST_PSCAN;
        end
      end
      ST_CWR: begin
        c_we = 1'b1; wslot_d = c_wsel; cache_v_d[c_wsel] = 1'b1; state_d = ST_PSCAN;
      end
      ST_PSCAN: begin
        if (sc_q < SCW'(PENDING_ENTRIES)) begin
          p_re = 1'b1; sc_d = sc_q + 1'b1; pv_d = 1'b1; pidx_d = sc_q[IW-1:0];
        end
        if (pv_q && pend_v_q[pidx_q[PW-1:0]]) begin
          if (kind_q == KIND_TICK) begin
            if ((now_q - p_stamp) > NOW_W'(tmo_q)) begin
              pend_v_d[pidx_q[PW-1:0]] = 1'b0;
              mask_d[pidx_q[PW-1:0]]   = 1'b1;
            end
          end else if (!pm_q && p_ip == peer_q) begin
            pm_d = 1'b1; pslot_d = pidx_q[PW-1:0];
          end
        end
        if (sc_q == SCW'(PENDING_ENTRIES) && !pv_q) begin
          case (kind_q)
            KIND_SEND: begin
              if (pm_q) begin
                slot_d = pslot_q; state_d = ST_ENQ;
              end else if (!(&pend_v_q)) begin
                slot_d = p_free_idx; state_d = ST_REQ;
              end else begin
                state_d = ST_DISC;
              end
            end
            KIND_ARP: begin
              slot_d  = pslot_q;
              state_d = (isreq_q && target_q == own_ip_q) ? ST_REPLY : ST_ARPF;
            end
            default: state_d = ST_TNEXT;
          endcase
        end
      end
      ST_TX: begin
        if (out_free) begin
          e_v = 1'b1; e_action = ACT_TX; e_mac = hmac_q; e_handle = handle_q;
          e_last = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_DLV: begin
        if (out_free) begin
          e_v = 1'b1; e_action = ACT_DELIVER; e_handle = handle_q;
          e_last = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_DISC: begin
        if (out_free) begin
          e_v = 1'b1; e_action = ACT_DISCARD; e_handle = handle_q;
          e_last = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_REQ: begin
        if (out_free) begin
          e_v = 1'b1; e_action = ACT_REQUEST; e_mac = BCAST_MAC; e_ip = peer_q;
          e_last = 1'b1; p_we = 1'b1; q_we = 1'b1;
          pend_v_d[slot_q] = 1'b1; qcnt_d[slot_q] = CNTW'(1); state_d = ST_IDLE;
        end
      end
      ST_ENQ: begin
        if (cur_cnt < CNTW'(QUEUE_DEPTH)) begin
          q_we = 1'b1; qcnt_d[slot_q] = cur_cnt + 1'b1; state_d = ST_IDLE;
        end else begin
          state_d = ST_DISC;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          e_v = 1'b1; e_action = ACT_REPLY; e_mac = smac_q; e_ip = peer_q;
          e_last = !(pm_q && cur_cnt != '0); state_d = ST_ARPF;
        end
      end
      ST_ARPF: begin
        j_d = '0;
        state_d = (pm_q && cur_cnt != '0) ? ST_FRD : ST_IDLE;
      end
      ST_TNEXT: begin
        j_d = '0; slot_d = em_idx;
        state_d = (em != '0) ? ST_FRD : ST_IDLE;
      end
      ST_FRD: begin
        q_re = 1'b1; state_d = ST_FEM;
      end
      ST_FEM: begin
        if (out_free) begin
          e_v = 1'b1; e_handle = q_rdata;
          if (kind_q == KIND_TICK) begin
            e_action = ACT_DISCARD;
            e_last   = last_j && ((em & ~(PENDING_ENTRIES'(1) << slot_q)) == '0);
          end else begin
            e_action = ACT_TX; e_mac = smac_q; e_last = last_j;
          end
          if (last_j) begin
            qcnt_d[slot_q] = '0;
            if (kind_q == KIND_TICK) begin
              mask_d[slot_q] = 1'b0; state_d = ST_TNEXT;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            j_d = j_q + 1'b1; state_d = ST_FRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit_load) begin
      n_d = n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; now_q <= '0; sc_q <= '0; pv_q <= 1'b0; pidx_q <= '0;
      hit_q <= 1'b0; minv_q <= 1'b0; pm_q <= 1'b0; slot_q <= '0; j_q <= '0;
      n_q <= '0; cache_v_q <= '0; pend_v_q <= '0; mask_q <= '0; mv_q <= 1'b0;
      wslot_q <= '0;
      for (int i = 0; i < PENDING_ENTRIES; i++) begin
        qcnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; now_q <= now_d; sc_q <= sc_d; pv_q <= pv_d; pidx_q <= pidx_d;
      hit_q <= hit_d; minv_q <= minv_d; pm_q <= pm_d; slot_q <= slot_d; j_q <= j_d;
      n_q <= n_d; cache_v_q <= cache_v_d; pend_v_q <= pend_v_d; mask_q <= mask_d;
      qcnt_q <= qcnt_d; wslot_q <= wslot_d;
      if (emit_load) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0; own_ip_q <= '0;
      life_q <= CACHE_LIFETIME_RST; tmo_q <= REQUEST_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OWN_MAC:         own_mac_q <= cfg_wdata_i;
        REG_OWN_IP:          own_ip_q  <= cfg_wdata_i[IP_W-1:0];
        REG_CACHE_LIFETIME:  life_q    <= cfg_wdata_i[MS_W-1:0];
        REG_REQUEST_TIMEOUT: tmo_q     <= cfg_wdata_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_e'(s_axis_tuser);
      peer_q   <= s_axis_tdata[79:48];
      target_q <= s_axis_tdata[111:80];
      smac_q   <= s_axis_tdata[159:112];
      isreq_q  <= s_axis_tdata[160];
      handle_q <= s_axis_tdata[177:162];
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_q <= hidx_d; hmac_q <= hmac_d; minst_q <= minst_d; minidx_q <= minidx_d;
    pslot_q <= pslot_d;
    if (emit_load) begin
      o_action_q <= e_action; o_mac_q <= e_mac; o_ip_q <= e_ip; o_handle_q <= e_handle;
      o_last_q   <= e_last || (n_q == RES_CNT_W'(MAX_RESULTS - 1));
    end
  end

  are_ram #(.WIDTH(CENT_W), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_wsel), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(sc_q[CW-1:0]), .rdata_o(c_rdata)
  );

  are_ram #(.WIDTH(PENT_W), .DEPTH(PENDING_ENTRIES)) u_pend_ram (
    .clk_i, .we_i(p_we), .waddr_i(slot_q), .wdata_i({peer_q, now_q}),
    .re_i(p_re), .raddr_i(sc_q[PW-1:0]), .rdata_o(p_rdata)
  );

  are_ram #(.WIDTH(HANDLE_W), .DEPTH(1 << QAW)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(handle_q),
    .re_i(q_re), .raddr_i({slot_q, j_q[QW-1:0]}), .rdata_o(q_rdata)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = o_action_q;
  assign m_axis_tdata  = {o_handle_q, o_ip_q, o_mac_q};
  assign m_axis_tlast  = o_last_q;

  `ARE_ASSERT(a_result_cap, n_q <= RES_CNT_W'(MAX_RESULTS), "result count beyond limit")
  `ARE_ASSERT_NEXT(a_cache_write, state_q == ST_CWR, cache_v_q[wslot_q], "learned entry not valid")
  `ARE_ASSERT(a_flush_bound, (state_q == ST_FEM) |-> (j_q < cur_cnt), "flush past queue fill")

endmodule
